// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the segment coder RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ssc_pkg.sv =====
// Types and constants of the secondary structure segment coder.
// No dependencies; imported by all coder modules.
package ssc_pkg;

    // residue class codes
    localparam logic [1:0] CLASS_OTHER  = 2'd0;
    localparam logic [1:0] CLASS_STRAND = 2'd1;
    localparam logic [1:0] CLASS_HELIX  = 2'd2;
    localparam logic [1:0] CLASS_RSVD   = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_STRAND = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_HELIX  = 1'b1;

    localparam int unsigned LEN_W = 6;
    localparam logic [LEN_W-1:0] LEN_MAX     = 6'd63;
    localparam logic [LEN_W-1:0] LEN_DEFAULT = 6'd4;

    // element code bases and axis offsets
    localparam int unsigned CODE_W = 4;
    localparam logic [CODE_W-1:0] BASE_STRAND = 4'd0;
    localparam logic [CODE_W-1:0] BASE_HELIX  = 4'd6;

    localparam logic [2:0] AXIS_PY = 3'd0;
    localparam logic [2:0] AXIS_PX = 3'd1;
    localparam logic [2:0] AXIS_NY = 3'd2;
    localparam logic [2:0] AXIS_NX = 3'd3;
    localparam logic [2:0] AXIS_PZ = 3'd4;
    localparam logic [2:0] AXIS_NZ = 3'd5;

    // one result item
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_result;

    // results produced by one residue, packed first-come first
    typedef struct packed {
        logic [1:0] cnt;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// ===== hw/rtl/ssc_dir.sv =====
// Dominant axis of an end-minus-start coordinate vector.
// Depends on ssc_pkg for the axis offset codes.
module ssc_dir #(
    parameter int unsigned COORD_WIDTH = 18
) (
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_z,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_z,
    output logic [2:0]                    o_axis
);
    import ssc_pkg::*;

    localparam int unsigned EW = COORD_WIDTH + 2;

    logic signed [EW-1:0] dx, dy, dz;
    logic signed [EW-1:0] ax, ay, az;
    logic px, nx, py, ny, pz;

    // differences and magnitudes, two guard bits so -|d| never overflows
    always_comb begin
        dx = EW'(i_end_x) - EW'(i_start_x);
        dy = EW'(i_end_y) - EW'(i_start_y);
        dz = EW'(i_end_z) - EW'(i_start_z);
        ax = dx[EW-1] ? -dx : dx;
        ay = dy[EW-1] ? -dy : dy;
        az = dz[EW-1] ? -dz : dz;
    end

    // axis tests in priority order: +x, -x, +y, -y, +z, then -z
    always_comb begin
        px = (dx >= ay) && (dx >= az);
        nx = (dx <= -ay) && (dx <= -az);
        py = (dy >= ax) && (dy >= az);
        ny = (dy <= -ax) && (dy <= -az);
        pz = (dz >= ax) && (dz >= ay);
        if (px) begin
            o_axis = AXIS_PX;
        end else if (nx) begin
            o_axis = AXIS_NX;
        end else if (py) begin
            o_axis = AXIS_PY;
        end else if (ny) begin
            o_axis = AXIS_NY;
        end else if (pz) begin
            o_axis = AXIS_PZ;
        end else begin
            o_axis = AXIS_NZ;
        end
    end

endmodule

// ===== hw/rtl/ssc_queue.sv =====
// Four-entry result queue: takes up to two results a cycle, gives one unless stalled.
// Depends on ssc_pkg for the result and push types.
`include "assert_macros.svh"

module ssc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ssc_pkg::t_push   i_push,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_stall,
    output ssc_pkg::t_result o_result
);
    import ssc_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result           r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr, n_rd_ptr, wr_ptr_b;
    logic [CNT_W-1:0]  n_count;
    logic              pop;

    // room for a two-result transfer, regardless of this cycle's pop
    assign o_room   = (r_count <= CNT_W'(DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && !i_stall;
    assign wr_ptr_b = r_wr_ptr + PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.cnt);
        n_rd_ptr = pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push.cnt) - CNT_W'(pop);
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr_b] <= i_push.second;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `ASSERT_SYNC(a_no_overflow, i_clk, i_rst_n, (r_count <= CNT_W'(DEPTH)), "queue overflow")
    `ASSERT_SYNC(a_ptr_count, i_clk, i_rst_n, ((r_wr_ptr - r_rd_ptr) == r_count[PTR_W-1:0]), "queue pointers disagree with count")

endmodule

// ===== hw/rtl/ssc_run.sv =====
// Input register, run tracking state and result formation for one residue.
// Depends on ssc_pkg and ssc_dir (two instances: closing and chain-end runs).
`include "assert_macros.svh"

module ssc_run #(
    parameter int unsigned COORD_WIDTH = 18
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [ssc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ssc_pkg::LEN_W-1:0]       i_cfg_wdata,
    // residue channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_res_class,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_y,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_z,
    input  logic                            i_chain_end,
    // queue side
    input  logic                            i_room,
    output ssc_pkg::t_push                  o_push
);
    import ssc_pkg::*;

    // configuration registers
    logic [LEN_W-1:0] r_min_strand, r_min_helix;

    // input register
    logic                          r_v;
    logic [1:0]                    r_cls;
    logic signed [COORD_WIDTH-1:0] r_x, r_y, r_z;
    logic                          r_end;

    // run state
    logic                          r_in_run;
    logic [1:0]                    r_prev_class;
    logic [LEN_W-1:0]              r_run_count;
    logic signed [COORD_WIDTH-1:0] r_start_x, r_start_y, r_start_z;
    logic signed [COORD_WIDTH-1:0] r_prev_x, r_prev_y, r_prev_z;

    logic                          n_in_run;
    logic [1:0]                    n_prev_class;
    logic [LEN_W-1:0]              n_run_count;

    logic             accept, adv;
    logic [1:0]       cls;
    logic             active, cont, close1, emit1, emit2, new_run;
    logic [LEN_W-1:0] min1, min2, mid_count;
    logic signed [COORD_WIDTH-1:0] s2_x, s2_y, s2_z;
    logic [2:0]       axis1, axis2;
    t_result          res1, res2;

    // handshake: the stage moves on whenever the queue has two free slots
    assign adv     = r_v && i_room;
    assign o_stall = r_v && !i_room;
    assign accept  = i_valid && !o_stall;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_strand <= LEN_DEFAULT;
            r_min_helix  <= LEN_DEFAULT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_MIN_STRAND: r_min_strand <= i_cfg_wdata;
                CFG_MIN_HELIX:  r_min_helix  <= i_cfg_wdata;
                default:        r_min_strand <= r_min_strand;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (adv) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls <= i_res_class;
            r_x   <= i_coord_x;
            r_y   <= i_coord_y;
            r_z   <= i_coord_z;
            r_end <= i_chain_end;
        end
    end

    // run update; the reserved class code counts as other
    always_comb begin
        cls     = (r_cls == CLASS_RSVD) ? CLASS_OTHER : r_cls;
        active  = (cls != CLASS_OTHER);
        cont    = r_in_run && (cls == r_prev_class);
        close1  = r_in_run && (cls != r_prev_class);
        new_run = active && !cont;
        min1    = (r_prev_class == CLASS_STRAND) ? r_min_strand : r_min_helix;
        min2    = (cls == CLASS_STRAND) ? r_min_strand : r_min_helix;
        emit1   = close1 && (r_run_count >= min1);

        if (!active) begin
            mid_count = '0;
        end else if (cont) begin
            mid_count = (r_run_count == LEN_MAX) ? LEN_MAX : r_run_count + LEN_W'(1);
        end else begin
            mid_count = LEN_W'(1);
        end

        // chain end flushes the run left open by this residue
        emit2        = r_end && active && (mid_count >= min2);
        n_in_run     = active && !r_end;
        n_run_count  = r_end ? '0 : mid_count;
        n_prev_class = r_end ? CLASS_OTHER : cls;
    end

    // start point of the run flushed at chain end
    assign s2_x = cont ? r_start_x : r_x;
    assign s2_y = cont ? r_start_y : r_y;
    assign s2_z = cont ? r_start_z : r_z;

    ssc_dir #(.COORD_WIDTH(COORD_WIDTH)) u_dir_close (
        .i_end_x   (r_prev_x),
        .i_end_y   (r_prev_y),
        .i_end_z   (r_prev_z),
        .i_start_x (r_start_x),
        .i_start_y (r_start_y),
        .i_start_z (r_start_z),
        .o_axis    (axis1)
    );

    ssc_dir #(.COORD_WIDTH(COORD_WIDTH)) u_dir_flush (
        .i_end_x   (r_x),
        .i_end_y   (r_y),
        .i_end_z   (r_z),
        .i_start_x (s2_x),
        .i_start_y (s2_y),
        .i_start_z (s2_z),
        .o_axis    (axis2)
    );

    // result formation; the later result carries run_last
    always_comb begin
        res1.code = ((r_prev_class == CLASS_STRAND) ? BASE_STRAND : BASE_HELIX)
                    + {1'b0, axis1};
        res1.last = !emit2;
        res2.code = ((cls == CLASS_STRAND) ? BASE_STRAND : BASE_HELIX) + {1'b0, axis2};
        res2.last = 1'b1;

        o_push.cnt    = adv ? (2'(emit1) + 2'(emit2)) : 2'd0;
        o_push.first  = emit1 ? res1 : res2;
        o_push.second = res2;
    end

    // run control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run     <= 1'b0;
            r_prev_class <= CLASS_OTHER;
            r_run_count  <= '0;
        end else if (adv) begin
            r_in_run     <= n_in_run;
            r_prev_class <= n_prev_class;
            r_run_count  <= n_run_count;
        end
    end

    // run coordinates
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prev_x <= r_x;
            r_prev_y <= r_y;
            r_prev_z <= r_z;
            if (new_run) begin
                r_start_x <= r_x;
                r_start_y <= r_y;
                r_start_z <= r_z;
            end
        end
    end

    `ASSERT_SYNC(a_run_has_class, i_clk, i_rst_n, (r_in_run |-> (r_prev_class == CLASS_STRAND || r_prev_class == CLASS_HELIX)), "open run without strand or helix class")
    `ASSERT_SYNC(a_run_count, i_clk, i_rst_n, (r_in_run == (r_run_count != '0)), "run count disagrees with open run")
    `ASSERT_SYNC(a_chain_flush, i_clk, i_rst_n, ((adv && r_end) |=> (!r_in_run && r_prev_class == CLASS_OTHER)), "run left open after chain end")

endmodule

// ===== hw/rtl/secondary_structure_segment_coder.sv =====
// Top level of the secondary structure segment coder.
// Depends on ssc_pkg, ssc_run (with ssc_dir) and ssc_queue.
//
// One residue is taken per clock unless stalled: the input register feeds
// the run tracker, which updates the open strand or helix run and forms up
// to two element codes in the same cycle, and these go into a four-entry
// result queue that delivers one code per clock when not stalled. A residue
// passes the input register, then the queue, before its first code is out.
// The residue channel stalls only while the queue has fewer than two free
// entries, so the rate is one residue per clock whenever the output side
// keeps taking codes, and residues that give two codes at once are absorbed by the queue.
module secondary_structure_segment_coder #(
    parameter int unsigned COORD_WIDTH = 18
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            i_cfg_wr_en,
    input  logic [ssc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ssc_pkg::LEN_W-1:0]       i_cfg_wdata,
    // residue channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_res_class,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_y,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_z,
    input  logic                            i_chain_end,
    // element code channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ssc_pkg::CODE_W-1:0]      o_element_code,
    output logic                            o_run_last
);
    import ssc_pkg::*;

    t_push   push;
    t_result result;
    logic    room;

    ssc_run #(.COORD_WIDTH(COORD_WIDTH)) u_run (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_res_class (i_res_class),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_coord_z   (i_coord_z),
        .i_chain_end (i_chain_end),
        .i_room      (room),
        .o_push      (push)
    );

    ssc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (result)
    );

    assign o_element_code = result.code;
    assign o_run_last     = result.last;

endmodule

// ===== tb/segment_code_checker.sv =====
// Checker for the secondary structure segment coder: watches both channels and the
// register port, predicts element codes per residue and compares them in order.
// Depends on ssc_pkg.
`timescale 1ns / 100ps

module segment_code_checker #(
    parameter int unsigned COORD_WIDTH = 18
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // register port, watched
    input  logic                            i_cfg_wr_en,
    input  logic [ssc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ssc_pkg::LEN_W-1:0]       i_cfg_wdata,
    // residue channel, watched
    input  logic                            i_res_valid,
    input  logic                            i_res_stall,
    input  logic [1:0]                      i_res_class,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_y,
    input  logic signed [COORD_WIDTH-1:0]   i_coord_z,
    input  logic                            i_chain_end,
    // element code channel, watched
    input  logic                            i_code_valid,
    input  logic                            i_code_stall,
    input  logic [ssc_pkg::CODE_W-1:0]      i_element_code,
    input  logic                            i_run_last,
    // to the testbench top
    output int                              o_fail_count,
    output int                              o_pending
);
    import ssc_pkg::*;

    // shadow registers
    logic [LEN_W-1:0] strand_min;
    logic [LEN_W-1:0] helix_min;

    // open run as the coder should see it
    logic             run_open;
    logic [1:0]       run_cls;
    logic [LEN_W-1:0] run_len;
    int               first_pt[3];
    int               latest_pt[3];

    t_result          expected_codes[$];
    int               produced;
    int               errors = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // Close the open run; queue its code if the run is long enough.
    task automatic close_run();
        logic [LEN_W-1:0] need;
        logic [2:0]       axis;
        longint           dx, dy, dz, ax, ay, az;
        t_result          code_item;
        need = (run_cls == CLASS_STRAND) ? strand_min : helix_min;
        if (run_len >= need) begin
            dx = longint'(latest_pt[0]) - longint'(first_pt[0]);
            dy = longint'(latest_pt[1]) - longint'(first_pt[1]);
            dz = longint'(latest_pt[2]) - longint'(first_pt[2]);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            az = (dz < 0) ? -dz : dz;
            // x before y before z, positive sign first on a tie
            if (dx >= ay && dx >= az)
                axis = AXIS_PX;
            else if (dx <= -ay && dx <= -az)
                axis = AXIS_NX;
            else if (dy >= ax && dy >= az)
                axis = AXIS_PY;
            else if (dy <= -ax && dy <= -az)
                axis = AXIS_NY;
            else if (dz >= ax && dz >= ay)
                axis = AXIS_PZ;
            else
                axis = AXIS_NZ;
            code_item.code = ((run_cls == CLASS_STRAND) ? BASE_STRAND : BASE_HELIX)
                             + {1'b0, axis};
            code_item.last = 1'b0;
            expected_codes.push_back(code_item);
            produced++;
        end
    endtask

    // Update the run with one residue and queue the codes it releases.
    task automatic track_residue(input logic [1:0] cls_in, input int x, input int y,
                                 input int z, input logic chain_done);
        logic [1:0] cls;
        t_result    tail;
        produced = 0;
        cls = (cls_in == CLASS_RSVD) ? CLASS_OTHER : cls_in;
        if (cls != CLASS_OTHER) begin
            if (run_open && cls == run_cls) begin
                if (run_len != LEN_MAX)
                    run_len++;
            end else begin
                if (run_open)
                    close_run();
                run_open = 1'b1;
                run_len = LEN_W'(1);
                first_pt = '{x, y, z};
            end
        end else if (run_open) begin
            close_run();
            run_open = 1'b0;
            run_len = '0;
        end
        run_cls = cls;
        latest_pt = '{x, y, z};
        // chain end flushes whatever is still open
        if (chain_done) begin
            if (run_open)
                close_run();
            run_open = 1'b0;
            run_len = '0;
            run_cls = CLASS_OTHER;
        end
        if (produced > 0) begin
            tail = expected_codes.pop_back();
            tail.last = 1'b1;
            expected_codes.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            strand_min = LEN_DEFAULT;
            helix_min = LEN_DEFAULT;
            run_open = 1'b0;
            run_cls = CLASS_OTHER;
            run_len = '0;
            first_pt = '{0, 0, 0};
            latest_pt = '{0, 0, 0};
            expected_codes.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_MIN_STRAND: strand_min = i_cfg_wdata;
                    CFG_MIN_HELIX:  helix_min = i_cfg_wdata;
                    default: ;
                endcase
            end
            // code transfer: compare with the oldest expectation
            if (i_code_valid && !i_code_stall) begin
                if (expected_codes.size() == 0) begin
                    report_mismatch($sformatf("code %0d arrived with none expected",
                                              i_element_code));
                end else begin
                    want = expected_codes.pop_front();
                    if (i_element_code !== want.code)
                        report_mismatch($sformatf("element_code %0d, expected %0d",
                                                  i_element_code, want.code));
                    if (i_run_last !== want.last)
                        report_mismatch($sformatf("run_last %0b, expected %0b",
                                                  i_run_last, want.last));
                end
            end
            // residue transfer
            if (i_res_valid && !i_res_stall)
                track_residue(i_res_class, int'(i_coord_x), int'(i_coord_y),
                              int'(i_coord_z), i_chain_end);
        end
        o_fail_count <= errors;
        o_pending <= expected_codes.size();
    end

endmodule

// ===== tb/tb_secondary_structure_segment_coder.sv =====
// Testbench top for the secondary structure segment coder: clock, reset, residue
// stimulus, random stalls, register writes and the verdict.
// Depends on ssc_pkg, the coder RTL and segment_code_checker.
`timescale 1ns / 100ps

module tb_secondary_structure_segment_coder;
    import ssc_pkg::*;

    localparam int COORD_W        = 18;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]     i_cfg_addr = CFG_MIN_STRAND;
    logic [LEN_W-1:0]          i_cfg_wdata = LEN_DEFAULT;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [1:0]                i_res_class = CLASS_OTHER;
    logic signed [COORD_W-1:0] i_coord_x = '0;
    logic signed [COORD_W-1:0] i_coord_y = '0;
    logic signed [COORD_W-1:0] i_coord_z = '0;
    logic                      i_chain_end = 1'b0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [CODE_W-1:0]         o_element_code;
    logic                      o_run_last;

    int fail_count;
    int pending;
    int idle_pct = 6;
    int stall_pct = 87;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    secondary_structure_segment_coder #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_res_class    (i_res_class),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_chain_end    (i_chain_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_element_code (o_element_code),
        .o_run_last     (o_run_last)
    );

    segment_code_checker #(
        .COORD_WIDTH(COORD_W)
    ) u_code_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_res_valid    (i_valid),
        .i_res_stall    (o_stall),
        .i_res_class    (i_res_class),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_chain_end    (i_chain_end),
        .i_code_valid   (o_valid),
        .i_code_stall   (i_stall),
        .i_element_code (o_element_code),
        .i_run_last     (o_run_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // receiver back-pressure
    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < stall_pct);

    // watchdog: too long without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: %0d cycles without a transfer", WATCHDOG_LIMIT);
            $display("tb_secondary_structure_segment_coder failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One residue transfer, after random idle cycles; valid stays up afterwards.
    task automatic send_residue(input logic [1:0] cls, input int x, input int y,
                                input int z, input logic chain_done);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_res_class <= cls;
        i_coord_x <= x[COORD_W-1:0];
        i_coord_y <= y[COORD_W-1:0];
        i_coord_z <= z[COORD_W-1:0];
        i_chain_end <= chain_done;
        do
            @(posedge i_clk);
        while (o_stall);
    endtask

    // Hold off the sender until every expected code is out and the pipe is empty.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [LEN_W-1:0] strand_len,
                               input logic [LEN_W-1:0] helix_len);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= CFG_MIN_STRAND;
        i_cfg_wdata <= strand_len;
        @(posedge i_clk);
        i_cfg_addr <= CFG_MIN_HELIX;
        i_cfg_wdata <= helix_len;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly full range, some extremes, some tiny values to force axis ties.
    function automatic int any_coord();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return ($urandom_range(1) == 1) ? 99999 : -99999;
        if (pick < 25)
            return int'($urandom_range(6)) - 3;
        return int'($urandom_range(199998)) - 99999;
    endfunction

    // Runs of one class with random length and content, occasional chain ends.
    task automatic random_residues(input int count);
        int         sent;
        int         run_length;
        int         pick;
        logic [1:0] cls;
        logic       chain_done;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 40)
                cls = CLASS_STRAND;
            else if (pick < 80)
                cls = CLASS_HELIX;
            else if (pick < 95)
                cls = CLASS_OTHER;
            else
                cls = CLASS_RSVD;
            // a few long runs reach the length counter's ceiling
            run_length = ($urandom_range(99) < 8) ? $urandom_range(80, 55)
                                                  : $urandom_range(8, 1);
            for (int k = 0; k < run_length; k++) begin
                if (k == run_length - 1)
                    chain_done = ($urandom_range(99) < 15);
                else
                    chain_done = ($urandom_range(99) < 2);
                send_residue(cls, any_coord(), any_coord(), any_coord(), chain_done);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset lengths: strand of four along +x, closed by a helix
        send_residue(CLASS_STRAND, -99999, -99999, -99999, 1'b0);
        send_residue(CLASS_STRAND, 0, 0, 0, 1'b0);
        send_residue(CLASS_STRAND, 0, 0, 0, 1'b0);
        send_residue(CLASS_STRAND, 99999, -99999, -99999, 1'b0);
        // helix of four along -z, flushed by chain end
        send_residue(CLASS_HELIX, 0, 0, 0, 1'b0);
        send_residue(CLASS_HELIX, 5, 5, 5, 1'b0);
        send_residue(CLASS_HELIX, -5, 5, 5, 1'b0);
        send_residue(CLASS_HELIX, 0, 0, -99999, 1'b1);
        // strand along +y, closed by the reserved class
        send_residue(CLASS_STRAND, 0, 0, 0, 1'b0);
        send_residue(CLASS_STRAND, 1, 1, 1, 1'b0);
        send_residue(CLASS_STRAND, -1, 2, 1, 1'b0);
        send_residue(CLASS_STRAND, 0, 5, 0, 1'b0);
        send_residue(CLASS_RSVD, 0, 0, 0, 1'b0);
        // helix too short to emit
        send_residue(CLASS_HELIX, 3, 3, 3, 1'b0);
        send_residue(CLASS_HELIX, 4, 4, 4, 1'b0);
        send_residue(CLASS_HELIX, 5, 5, 5, 1'b0);
        send_residue(CLASS_OTHER, 6, 6, 6, 1'b1);

        // zero minimum: single residues emit, null vector gives +x
        reconfigure(LEN_W'(0), LEN_W'(0));
        send_residue(CLASS_HELIX, 0, 0, 0, 1'b1);
        // class change with chain end: two codes from one residue
        send_residue(CLASS_STRAND, 1, 1, 1, 1'b0);
        send_residue(CLASS_STRAND, 1, -50, 1, 1'b0);
        send_residue(CLASS_HELIX, 7, 7, 7, 1'b1);
        send_residue(CLASS_OTHER, 99999, 99999, 99999, 1'b1);
        // x and y tie in magnitude, x negative and y positive
        send_residue(CLASS_STRAND, 0, 0, 0, 1'b0);
        send_residue(CLASS_STRAND, -10, 10, 0, 1'b0);
        send_residue(CLASS_OTHER, 0, 0, 0, 1'b0);

        // heavy receiver stall
        reconfigure(LEN_W'(2), LEN_W'(5));
        idle_pct = 6;
        stall_pct <= 87;
        random_residues(330);

        // sparse sender, extreme lengths
        reconfigure(LEN_W'(0), LEN_W'(63));
        idle_pct = 87;
        stall_pct <= 6;
        random_residues(330);

        // full rate
        reconfigure(LEN_W'(63), LEN_W'(0));
        idle_pct = 0;
        stall_pct <= 0;
        random_residues(340);

        settle();
        if (fail_count == 0 && pending == 0)
            $display("tb_secondary_structure_segment_coder passed");
        else
            $display("tb_secondary_structure_segment_coder failed");
        $finish;
    end

endmodule
